>>> sv/pds_pkg.sv
// Package for the 2x2 pixel downsampler: widths, register indexes, mode codes, reset values.
// No dependencies; every other file of the block but pds_ram imports it.
package pds_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 13;
    localparam int SIZE_W     = 13;
    localparam int SUM_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int MAX_LINE_DEF = 4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_HEIGHT  = 3'd5;

    // Mode codes
    localparam logic MODE_BOX  = 1'b0;
    localparam logic MODE_KEEP = 1'b1;

    // Register reset values
    localparam logic [SIZE_W-1:0] LINE_LENGTH_RST = 13'd4096;
    localparam logic [COL_W-1:0]  CROP_X_RST      = 12'd0;
    localparam logic [COL_W-1:0]  CROP_Y_RST      = 12'd0;
    localparam logic [SIZE_W-1:0] PIC_WIDTH_RST   = 13'd4096;
    localparam logic [SIZE_W-1:0] PIC_HEIGHT_RST  = 13'd4096;

endpackage

>>> sv/pds_in_if.sv
// Input pixel channel of the 2x2 downsampler: valid/ready plus pixel payload.
// Depends on pds_pkg for field widths.
interface pds_in_if import pds_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             plane_start;

    modport source (output valid, output pixel, output plane_start, input ready);
    modport sink   (input valid, input pixel, input plane_start, output ready);
endinterface

>>> sv/pds_out_if.sv
// Output pixel channel of the 2x2 downsampler: valid/ready plus result payload.
// Depends on pds_pkg for field widths.
interface pds_out_if import pds_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             plane_done;

    modport source (output valid, output pixel_out, output plane_done, input ready);
    modport sink   (input valid, input pixel_out, input plane_done, output ready);
endinterface

>>> sv/pds_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while the read enable is low. No dependencies.
module pds_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pixel_2x2_downsampler.sv
// Top level of the 2x2 pixel downsampler (crop window, box average or top-left).
// Depends on pds_pkg, pds_in_if, pds_out_if and pds_ram.
//
// Usage:
//   i_pix  : one 8-bit source pixel per transfer, plane in raster order;
//            plane_start marks row 0 / column 0 of a new plane.
//   o_pix  : one result per 2x2 block of the crop window, produced on the
//            odd column of each odd window row; plane_done flags the
//            bottom-right block of the window.
//   i_cfg_*: register writes, index per pds_pkg CFG_* codes. Write only
//            between planes while the block is empty.
// Throughput: one pixel per cycle, sustained. Every pixel is accepted the
//   cycle it arrives unless a result is stuck in the pipe.
// Pipeline: an input transfer goes through the read stage (the registered read
//   of the line store) and then the output register to o_pix.valid.
// Line store: MAX_LINE/2 entries of 9 bits holding the even-row pair sums
//   (or the top-left pixel in keep mode). It is not cleared at reset; there
//   is no clearing pass, the block takes pixels right after reset.
// Reset: synchronous, active low; clears counters, held pixel, registers to
//   their defaults and empties the pipe.
// Stall: while o_pix.ready is low with a result waiting, the result stays and
//   one more item may sit in the read stage; after that i_pix.ready drops.
module pixel_2x2_downsampler import pds_pkg::*; #(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pds_in_if.sink                i_pix,
    pds_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LINE_SLOTS = MAX_LINE / 2;
    localparam int AW         = $clog2(LINE_SLOTS);

    // Configuration registers
    logic              r_mode;
    logic [SIZE_W-1:0] r_line_length;
    logic [COL_W-1:0]  r_crop_x;
    logic [COL_W-1:0]  r_crop_y;
    logic [SIZE_W-1:0] r_pic_width;
    logic [SIZE_W-1:0] r_pic_height;

    // Position state
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_held, n_held;

    // Read stage (item waiting for line-store data)
    logic             r_s1_valid;
    logic             r_s1_mode;
    logic             r_s1_in_store;
    logic             r_s1_last;
    logic [PIX_W-1:0] r_s1_held;
    logic [PIX_W-1:0] r_s1_pix;

    // Output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_done;

    // Handshake
    logic in_xfer;
    logic out_load;
    logic s1_free;

    // Position decode
    logic [COL_W-1:0]    col_eff;
    logic [ROW_W-1:0]    row_eff;
    logic [SIZE_W-1:0]   w_even;
    logic [SIZE_W-1:0]   h_even;
    logic [SIZE_W:0]     x_end;
    logic [SIZE_W:0]     y_end;
    logic                in_win;
    logic [COL_W-1:0]    dx;
    logic [ROW_W-1:0]    dy;
    logic [COL_W-2:0]    slot;
    logic                in_store;
    logic                is_write;
    logic                is_read;
    logic                is_last;
    logic                row_end;
    logic [SUM_W-1:0]    wr_data;
    logic [SUM_W-1:0]    rd_data;
    logic [SUM_W-1:0]    above;
    logic [SUM_W:0]      box_sum;
    logic [PIX_W-1:0]    result;

    // The output register loads when it is empty or being drained; the read
    // stage frees up whenever its content moves on.
    assign out_load = !r_out_valid || o_pix.ready;
    assign s1_free  = !r_s1_valid || out_load;
    assign i_pix.ready = s1_free;
    assign in_xfer  = i_pix.valid && s1_free;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_BOX;
            r_line_length <= LINE_LENGTH_RST;
            r_crop_x      <= CROP_X_RST;
            r_crop_y      <= CROP_Y_RST;
            r_pic_width   <= PIC_WIDTH_RST;
            r_pic_height  <= PIC_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:        r_mode        <= i_cfg_data[0];
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data;
                CFG_CROP_X:      r_crop_x      <= i_cfg_data[COL_W-1:0];
                CFG_CROP_Y:      r_crop_y      <= i_cfg_data[COL_W-1:0];
                CFG_PIC_WIDTH:   r_pic_width   <= i_cfg_data;
                CFG_PIC_HEIGHT:  r_pic_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- position and window decode ----------------
    always_comb begin
        col_eff = i_pix.plane_start ? '0 : r_col;
        row_eff = i_pix.plane_start ? '0 : r_row;
        // odd sizes drop their low bit
        w_even  = {r_pic_width[SIZE_W-1:1], 1'b0};
        h_even  = {r_pic_height[SIZE_W-1:1], 1'b0};
        x_end   = {2'b00, r_crop_x} + {1'b0, w_even};
        y_end   = {2'b00, r_crop_y} + {1'b0, h_even};

        in_win  = (col_eff >= r_crop_x) && ({2'b00, col_eff} < x_end) &&
                  (row_eff >= {1'b0, r_crop_y}) && ({1'b0, row_eff} < y_end);

        dx      = col_eff - r_crop_x;
        dy      = row_eff - {1'b0, r_crop_y};
        slot    = dx[COL_W-1:1];
        in_store = 32'(slot) < 32'(LINE_SLOTS);

        // even column: hold pixel; odd column: store on even rows, emit on odd
        is_write = in_win && dx[0] && !dy[0];
        is_read  = in_win && dx[0] && dy[0];
        is_last  = ({1'b0, dx} == w_even - 13'd1) && (dy == h_even - 13'd1);

        wr_data  = (r_mode == MODE_KEEP) ? {1'b0, r_held}
                                         : {1'b0, r_held} + {1'b0, i_pix.pixel};

        // row ends after line_length pixels or at the top column value
        row_end = (({1'b0, col_eff} + 13'd1) >= r_line_length) || (col_eff == '1);

        n_col  = row_end ? '0 : col_eff + 12'd1;
        n_row  = (row_end && (row_eff != '1)) ? row_eff + 13'd1 : row_eff;
        n_held = (in_win && !dx[0]) ? i_pix.pixel : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (in_xfer) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_held <= n_held;
        end
    end

    // ---------------- line store ----------------
    pds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LINE_SLOTS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (in_xfer && is_write && in_store),
        .i_waddr (AW'(slot)),
        .i_wdata (wr_data),
        .i_re    (in_xfer && is_read),
        .i_raddr (AW'(slot)),
        .o_rdata (rd_data)
    );

    // ---------------- read stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_xfer && is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_mode     <= r_mode;
            r_s1_in_store <= in_store;
            r_s1_last     <= is_last;
            r_s1_held     <= r_held;
            r_s1_pix      <= i_pix.pixel;
        end
    end

    // A block past the line store reads as zero.
    always_comb begin
        above   = r_s1_in_store ? rd_data : '0;
        box_sum = {1'b0, above} + {2'b00, r_s1_held} + {2'b00, r_s1_pix};
        result  = (r_s1_mode == MODE_KEEP) ? above[PIX_W-1:0] : box_sum[SUM_W:2];
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_pixel <= result;
            r_out_done  <= r_s1_last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_out  = r_out_pixel;
    assign o_pix.plane_done = r_out_done;

endmodule

>>> sv/pds_checker.sv
// Port-level checks for the 2x2 downsampler, attached by bind.
// Depends on pds_pkg and the pixel_2x2_downsampler top level.
module pds_checker import pds_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_out_pixel,
    input logic             i_out_done
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel) && $stable(i_out_done))
        else $error("result payload changed while stalled");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // An output appearing from empty comes from an input transfer that went into
    // the read stage and from there into the output register.
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a preceding input transfer");

    // With the output free, the input side is never blocked.
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output");

endmodule

bind pixel_2x2_downsampler pds_checker u_pds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out),
    .i_out_done  (o_pix.plane_done)
);

>>> verif/tb_pixel_2x2_downsampler.sv
// Self-checking testbench for pixel_2x2_downsampler: crop window, box average and
// top-left keep mode, with bursty input, stalling output and a scoreboard predictor.
// Depends on pds_pkg, pds_in_if, pds_out_if and the block's RTL.
module tb_pixel_2x2_downsampler;
    import pds_pkg::*;

    localparam int RANDOM_PIXELS = 1450;
    localparam int HOLD_CYCLES   = 300;   // long output hold-off, fills the pipe
    localparam int DRAIN_CYCLES  = 4;     // pixels with no result
                                          // may still sit in the pipe

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             plane_done;
    } t_block;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} t_stall_style;

    // Predicts the downsampled blocks from the accepted pixels and checks the
    // results against them in order.
    class t_downsample_scoreboard;
        logic              mode;
        logic [SIZE_W-1:0] line_len;
        logic [COL_W-1:0]  crop_x;
        logic [COL_W-1:0]  crop_y;
        logic [SIZE_W-1:0] pic_w;
        logic [SIZE_W-1:0] pic_h;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [PIX_W-1:0]  held_left;
        logic [SUM_W-1:0]  pair_line [MAX_LINE_DEF/2];
        t_block            expected_blocks [$];
        int                errors;
        int                checked;

        function new();
            mode      = MODE_BOX;
            line_len  = LINE_LENGTH_RST;
            crop_x    = CROP_X_RST;
            crop_y    = CROP_Y_RST;
            pic_w     = PIC_WIDTH_RST;
            pic_h     = PIC_HEIGHT_RST;
            col       = '0;
            row       = '0;
            held_left = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:        mode     = data[0];
                CFG_LINE_LENGTH: line_len = data[SIZE_W-1:0];
                CFG_CROP_X:      crop_x   = data[COL_W-1:0];
                CFG_CROP_Y:      crop_y   = data[COL_W-1:0];
                CFG_PIC_WIDTH:   pic_w    = data[SIZE_W-1:0];
                CFG_PIC_HEIGHT:  pic_h    = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic start);
            int                wv;
            int                hv;
            int                dx;
            int                dy;
            int                slot;
            logic [SUM_W-1:0]  above;
            logic [PIX_W+1:0]  box_sum;
            t_block            blk;
            wv = int'(pic_w) & ~1;
            hv = int'(pic_h) & ~1;
            if (start) begin
                col = '0;
                row = '0;
            end
            dx = int'(col) - int'(crop_x);
            dy = int'(row) - int'(crop_y);
            if (dx >= 0 && dx < wv && dy >= 0 && dy < hv) begin
                slot = dx >> 1;
                if (dx % 2 == 0) begin
                    held_left = pix;
                end else if (dy % 2 == 0) begin
                    // even row: remember the pair (or just the left pixel)
                    pair_line[slot] = (mode == MODE_KEEP) ? {1'b0, held_left}
                                                          : {1'b0, held_left} + {1'b0, pix};
                end else begin
                    above = pair_line[slot];
                    if (mode == MODE_KEEP) begin
                        blk.pixel_out = above[PIX_W-1:0];
                    end else begin
                        box_sum = above + held_left + pix;
                        blk.pixel_out = box_sum[PIX_W+1:2];
                    end
                    blk.plane_done = (dx == wv - 1 && dy == hv - 1);
                    expected_blocks.push_back(blk);
                end
            end
            // row ends at line_length or at the last column the counter holds
            if (int'(col) + 1 >= int'(line_len) || col == {COL_W{1'b1}}) begin
                col = '0;
                if (row != {ROW_W{1'b1}})
                    row = row + 1'b1;
            end else begin
                col = col + 1'b1;
            end
        endfunction

        function void check_block(logic [PIX_W-1:0] pix, logic done);
            t_block want;
            checked++;
            if (expected_blocks.size() == 0) begin
                $error("unexpected result: pixel_out %0d plane_done %0d", pix, done);
                errors++;
                return;
            end
            want = expected_blocks.pop_front();
            if (pix !== want.pixel_out) begin
                $error("pixel_out: expected %0d, actual %0d", want.pixel_out, pix);
                errors++;
            end
            if (done !== want.plane_done) begin
                $error("plane_done: expected %0d, actual %0d", want.plane_done, done);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pds_in_if  pix_ch ();
    pds_out_if blk_ch ();

    t_downsample_scoreboard sb = new();

    int pixels_sent  = 0;
    int planes_run   = 0;
    int burst_left   = 0;
    bit hold_request = 1'b0;
    bit hold_used    = 1'b0;

    pixel_2x2_downsampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .o_pix       (blk_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #800000;
        $error("timeout: %0d results still expected", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output side: every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && blk_ch.valid && blk_ch.ready)
            sb.check_block(blk_ch.pixel_out, blk_ch.plane_done);
    end

    // Receiver: stall style changes after a random window; style NONE gives
    // stretches with no stalls. A hold request parks ready low for a long hold-off
    // so the block backs up into its input.
    initial begin : receiver
        t_stall_style style;
        int           window_left;
        int           tick;
        style       = STALL_NONE;
        window_left = 0;
        tick        = 0;
        blk_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                blk_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            if (window_left == 0) begin
                style       = t_stall_style'($urandom_range(0, 3));
                window_left = $urandom_range(20, 200);
            end
            window_left--;
            tick++;
            case (style)
                STALL_NONE:     blk_ch.ready <= 1'b1;
                STALL_LIGHT:    blk_ch.ready <= ($urandom_range(0, 9) >= 3);
                STALL_PERIODIC: blk_ch.ready <= (tick % 3 != 0);
                default:        blk_ch.ready <= ($urandom_range(0, 9) >= 7);
            endcase
        end
    end

    // One pixel transfer. The sender runs in bursts; between bursts valid drops
    // for a random gap (sometimes none, so bursts run back to back).
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel       <= pix;
        pix_ch.plane_start <= start;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        sb.note_pixel(pix, start);
        pixels_sent++;
    endtask

    // Stop offering pixels and let the block empty out; registers may be
    // written once this returns.
    task automatic drain_block();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after its last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_plane(logic m, int ll, int cx, int cy, int w, int h);
        write_reg(CFG_MODE, CFG_DATA_W'(m));
        write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(ll));
        write_reg(CFG_CROP_X, CFG_DATA_W'(cx));
        write_reg(CFG_CROP_Y, CFG_DATA_W'(cy));
        write_reg(CFG_PIC_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_PIC_HEIGHT, CFG_DATA_W'(h));
        cfg_we <= 1'b0;
    endtask

    // Mostly whole planes with random content. Some are cut short, some run on
    // past the window, some continue the previous plane without a start marker,
    // and a stray start marker now and then restarts the counters mid-plane.
    // A new setting is always followed by a start marker, so an odd window row
    // never reads a line entry that its even row did not write.
    task automatic run_random_plane();
        int               ll;
        int               cx;
        int               cy;
        int               w;
        int               h;
        int               total;
        int               i;
        logic             m;
        logic             restart;
        logic             start;
        logic [PIX_W-1:0] pix;
        restart = 1'b1;
        if (planes_run > 0 && $urandom_range(0, 5) == 0) begin
            restart = 1'b0;
            total   = $urandom_range(4, 60);
        end else begin
            m = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0:       ll = 2;
                1:       ll = $urandom_range(24, 40);
                default: ll = $urandom_range(2, 16);
            endcase
            cx = $urandom_range(0, ll - 2);
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);                 // no blocks at all
                1:       w = ll - cx + $urandom_range(1, 4);       // clipped by line end
                default: w = $urandom_range(2, ll - cx);
            endcase
            h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            cy = $urandom_range(0, 3);
            drain_block();
            program_plane(m, ll, cx, cy, w, h);
            total = (cy + h + $urandom_range(0, 1)) * ll;
            if (total == 0)
                total = ll;
            if ($urandom_range(0, 7) == 0)
                total = $urandom_range(1, total);
            if (!hold_used && pixels_sent > 400 && w >= 2 && h >= 2 && cx + 2 <= ll) begin
                hold_request = 1'b1;
                hold_used    = 1'b1;
            end
        end
        for (i = 0; i < total; i++) begin
            start = (i == 0 && restart) || ($urandom_range(0, 299) == 0);
            pix   = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                : 8'($urandom);
            send_pixel(pix, start);
        end
        planes_run++;
    endtask

    initial begin : stimulus
        int directed_pixels;
        i_rst_n            <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel       <= '0;
        pix_ch.plane_start <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_MODE;
        cfg_data           <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: full 4096 window, box mode; first row only.
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);

        // Offset window, odd width (low bit dropped), one block. The even row
        // goes in under box mode (pair sum 510), then the mode flips to keep
        // and the odd row continues without a start marker: the keep result
        // is the low byte of what the store holds.
        drain_block();
        program_plane(MODE_BOX, 4, 1, 1, 3, 2);
        send_pixel(8'h12, 1'b1);
        send_pixel(8'h34, 1'b0);
        send_pixel(8'h56, 1'b0);
        send_pixel(8'h78, 1'b0);
        send_pixel(8'h9A, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hBC, 1'b0);
        drain_block();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_KEEP));
        cfg_we <= 1'b0;
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h80, 1'b0);

        // Line length 0, then 1: every pixel ends its row, so no odd columns.
        drain_block();
        program_plane(MODE_BOX, 0, 0, 0, 2, 2);
        send_pixel(8'hC3, 1'b1);
        send_pixel(8'h3C, 1'b0);
        send_pixel(8'hAA, 1'b0);
        drain_block();
        write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(1));
        cfg_we <= 1'b0;
        send_pixel(8'h55, 1'b1);
        send_pixel(8'h0F, 1'b0);

        // Width below 2 with odd height: window is empty.
        drain_block();
        program_plane(MODE_KEEP, 2, 0, 0, 1, 3);
        send_pixel(8'hF0, 1'b1);
        send_pixel(8'h11, 1'b0);
        send_pixel(8'h22, 1'b0);
        send_pixel(8'h33, 1'b0);

        // Register extremes: window starts far beyond the pixels sent.
        drain_block();
        program_plane(MODE_KEEP, 8191, 4094, 4094, 8191, 8191);
        send_pixel(8'h7F, 1'b1);
        send_pixel(8'h80, 1'b0);
        directed_pixels = pixels_sent;

        while (pixels_sent < directed_pixels + RANDOM_PIXELS)
            run_random_plane();

        drain_block();

        $display("Run covered %0d pixel transfers over %0d random planes plus directed cases;",
                 pixels_sent, planes_run);
        $display("%0d downsampled results checked, long output hold-off %s.",
                 sb.checked, hold_used ? "exercised" : "not reached");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
